>>> rtl/volatility_target_exposure_defines.svh
// assertion macros for the volatility target exposure block
// used by the top level only, expects clk and rst_n in scope
`ifndef VOLATILITY_TARGET_EXPOSURE_DEFINES_SVH
`define VOLATILITY_TARGET_EXPOSURE_DEFINES_SVH

// same-cycle implication
`define VTE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define VTE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/vte_pkg.sv
// shared types and constants of the volatility target exposure block
// no dependencies
`timescale 1ns / 1ps

package vte_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int RING_W     = 33;
  localparam int WIN_W      = 9;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int TENTHS_W   = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 2'd2;

  localparam logic [CFG_W-1:0] TARGET_RESET = 24'd9830;
  localparam logic [CFG_W-1:0] CAP_RESET    = 24'd131072;
  localparam logic [WIN_W-1:0] WIN_RESET    = 9'd20;
  localparam logic [WIN_W-1:0] WIN_MIN      = 9'd2;
  localparam logic [WIN_W-1:0] WIN_MAX      = WIN_W'(MAX_WINDOW);

  typedef enum logic [1:0] {
    REASON_VALID    = 2'd0,
    REASON_WARMUP   = 2'd1,
    REASON_BAD      = 2'd2,
    REASON_ZERO_VAR = 2'd3
  } reason_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RET_START,
    OP_RET_FIN,
    OP_RET_BAD,
    OP_RD_OLD,
    OP_SQ_OLD,
    OP_SUB_OLD,
    OP_SQ_NEW,
    OP_ADD_NEW,
    OP_HIST,
    OP_MEAN_START,
    OP_MEAN_FIN,
    OP_MSQ_START,
    OP_MSQ_FIN,
    OP_MM,
    OP_VAR,
    OP_SQRT_START,
    OP_TGT_START,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t     op;
    reason_t reason;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic prev_nonpos;
    logic full;
    logic bad_any;
    logic var_nonpos;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/volatility_target_exposure.sv
// Volatility target exposure: one closing price in, one exposure result out per transaction.
// A close that is the first of a history goes straight to the history update; after a close
// that was not positive the return is marked bad without a division. Otherwise the return is
// divided. No volatility follows while warming up or while a bad close is still in the window;
// else the mean and mean square are divided out and the variance checked, and only when it is
// positive are the square root and target ratio computed. The shared 64-step divider runs up
// to four times (return, mean, mean square, target ratio).
// A new close is taken the cycle after the previous one has left the controller. A finished
// result waits in an output register, so the next close can start while the result is not
// yet taken. Only a result that finds the register still full holds the controller, for as
// long as the register waits. Writing the window length restarts history. The return ring
// lives in a 256-entry memory with no clearing pass.
// depends on vte_pkg, vte_ctrl, vte_datapath and the assertion macro header
`timescale 1ns / 1ps

`include "volatility_target_exposure_defines.svh"

module volatility_target_exposure (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transaction
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,    // [31:0] close_price (signed)
  // result transaction
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,   // [11:0] exposure_tenths, rest zero
  output logic [1:0]                    out_tuser,   // [1:0] zero_reason
  // configuration writes
  input  logic                          cfg_we,
  input  logic [vte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vte_pkg::CFG_W-1:0]     cfg_wdata
);

  import vte_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller decides the sequence, datapath holds all arithmetic and history
  vte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  vte_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // one close at a time: busy right after acceptance
  `VTE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  // a result never overwrites one still waiting
  `VTE_ASSERT_NOW(a_emit_free, cmd.op == OP_EMIT, !out_tvalid || out_tready, "result overwritten")
  // zero exposure whenever a reason is given
  `VTE_ASSERT_NOW(a_zero_reason, out_tvalid && out_tuser != REASON_VALID,
                  out_tdata[11:0] == '0, "nonzero exposure with reason")

endmodule

>>> rtl/vte_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module vte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> rtl/vte_div.sv
// iterative restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle
// no dependencies
`timescale 1ns / 1ps

module vte_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [63:0] quotient,
  output logic        rem_nz,
  output logic        done
);

  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem_r, q_r[63]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[62:0], fits};
      rem_r <= fits ? 32'(trial - {1'b0, d_r}) : trial[31:0];
    end
  end

  assign quotient = q_r;
  assign rem_nz   = |rem_r;
  assign done     = done_r;

endmodule

>>> rtl/vte_datapath.sv
// datapath: return ring, running sums, shared divider, square root and output register
// depends on vte_pkg, vte_ram, vte_div
`timescale 1ns / 1ps

module vte_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   in_tdata,
  input  logic                          cfg_we,
  input  logic [vte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vte_pkg::CFG_W-1:0]     cfg_wdata,
  input  vte_pkg::cmd_t                 cmd,
  output vte_pkg::status_t              status,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,
  output logic [1:0]                    out_tuser
);

  import vte_pkg::*;

  // configuration
  logic [CFG_W-1:0] target_r, cap_r;
  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] win_wr;

  // history
  logic signed [31:0] close_r, prev_r;
  logic [WIN_W-1:0]   bars_r;
  logic [RING_AW-1:0] pos_r;
  logic signed [39:0] sum_r;
  logic [63:0]        sqsum_r;
  logic [WIN_W-1:0]   bad_r;

  // working registers
  logic signed [31:0] e_val_r;
  logic               e_bad_r;
  logic [63:0]        prod_r;
  logic [31:0]        m_r;
  logic [63:0]        sqm_r;
  logic               var_nonpos_r;
  logic [63:0]        rad_r;
  logic               ret_neg_r;

  // square root
  logic [63:0] x_r;
  logic [34:0] srem_r;
  logic [31:0] root_r;
  logic [4:0]  scnt_r;
  logic        sbusy_r, sdone_r;
  logic [34:0] srem_t, strial;
  logic        sfits;

  // output register
  logic                out_valid_r;
  logic [TENTHS_W-1:0] out_tenths_r;
  reason_t             out_reason_r;

  // ring
  logic              ram_wr, ram_rd;
  logic [RING_W-1:0] ram_rdata;

  // divider
  logic        div_start;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;
  logic        div_nz, div_done;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [39:0]        abs_sum;
  logic [35:0]        tgt_num;
  logic [27:0]        cap_x10;
  logic [11:0]        cap_t;
  logic [64:0]        qm;
  logic               sat_pos, sat_neg;
  logic signed [32:0] mul_a;
  logic signed [65:0] mul_p;
  logic signed [64:0] v;
  logic [WIN_W:0]     win_p1;
  logic [RING_AW:0]   pos_inc;
  logic [63:0]        tgt_t;
  logic [11:0]        tenths;

  assign diff    = 33'(close_r) - 33'(prev_r);
  assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
  assign abs_sum = sum_r[39] ? 40'(-sum_r) : 40'(sum_r);
  assign tgt_num = {target_r, 11'b0} + {2'b0, target_r, 9'b0} + 36'd0;
  assign cap_x10 = {1'b0, cap_r, 3'b0} + {3'b0, cap_r, 1'b0};
  assign cap_t   = cap_x10[27:16];
  assign win_p1  = {1'b0, win_r} + 1'b1;
  assign pos_inc = {1'b0, pos_r} + 1'b1;

  // window write is clamped into range
  always_comb begin
    win_wr = cfg_wdata[WIN_W-1:0];
    if (win_wr < WIN_MIN) begin
      win_wr = WIN_MIN;
    end else if (win_wr > WIN_MAX) begin
      win_wr = WIN_MAX;
    end
  end

  // shared divider operand selection
  always_comb begin
    div_start    = 1'b1;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_RET_START: begin
        div_dividend = {1'b0, mag, 30'b0};
        div_divisor  = prev_r;
      end
      OP_MEAN_START: begin
        div_dividend = {24'b0, abs_sum};
        div_divisor  = {23'b0, win_r};
      end
      OP_MSQ_START: begin
        div_dividend = sqsum_r;
        div_divisor  = {23'b0, win_r};
      end
      OP_TGT_START: begin
        div_dividend = {28'b0, tgt_num};
        div_divisor  = root_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  vte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .rem_nz   (div_nz),
    .done     (div_done)
  );

  assign ram_wr = cmd.op == OP_ADD_NEW;
  assign ram_rd = cmd.op == OP_RD_OLD;

  vte_ram #(
    .WIDTH (RING_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (pos_r),
    .wr_data ({e_bad_r, e_val_r}),
    .rd_en   (ram_rd),
    .rd_addr (pos_r),
    .rd_data (ram_rdata)
  );

  // floor division fix-up and q2.30 saturation
  assign qm      = {1'b0, div_q} + {64'b0, div_nz};
  assign sat_pos = |div_q[63:31];
  assign sat_neg = (|qm[64:32]) || (qm[31] && (|qm[30:0]));

  // one squarer serves the old return, the new return and the mean
  always_comb begin
    case (cmd.op)
      OP_SQ_OLD: mul_a = 33'(signed'(ram_rdata[31:0]));
      OP_SQ_NEW: mul_a = 33'(e_val_r);
      default:   mul_a = signed'({1'b0, m_r});
    endcase
  end
  assign mul_p = mul_a * mul_a;

  assign v = signed'({1'b0, sqm_r}) - signed'({13'b0, prod_r[63:12]});

  assign srem_t = {srem_r[32:0], x_r[63:62]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sfits  = srem_t >= strial;

  assign tgt_t  = (root_r == '0) ? {52'b0, cap_t} : div_q;
  assign tenths = (tgt_t < {52'b0, cap_t}) ? tgt_t[11:0] : cap_t;

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      cap_r       <= CAP_RESET;
      win_r       <= WIN_RESET;
      prev_r      <= '0;
      bars_r      <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      bad_r       <= '0;
      sbusy_r     <= 1'b0;
      sdone_r     <= 1'b0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sdone_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_TARGET: target_r <= cfg_wdata;
          CFG_IDX_CAP:    cap_r    <= cfg_wdata;
          CFG_IDX_WINDOW: begin
            win_r   <= win_wr;
            prev_r  <= '0;
            bars_r  <= '0;
            pos_r   <= '0;
            sum_r   <= '0;
            sqsum_r <= '0;
            bad_r   <= '0;
          end
          default: ;
        endcase
      end
      case (cmd.op)
        OP_SUB_OLD: begin
          sum_r   <= sum_r - 40'(signed'(ram_rdata[31:0]));
          sqsum_r <= sqsum_r - {12'b0, prod_r[63:12]};
          if (ram_rdata[32]) begin
            bad_r <= bad_r - 1'b1;
          end
        end
        OP_ADD_NEW: begin
          sum_r   <= sum_r + 40'(e_val_r);
          sqsum_r <= sqsum_r + {12'b0, prod_r[63:12]};
          bad_r   <= bad_r + {8'b0, e_bad_r};
          pos_r   <= ({1'b0, pos_inc} >= {1'b0, win_r}) ? '0 : pos_inc[RING_AW-1:0];
        end
        OP_HIST: begin
          prev_r <= close_r;
          if ({1'b0, bars_r} < win_p1) begin
            bars_r <= bars_r + 1'b1;
          end
        end
        OP_SQRT_START: begin
          sbusy_r <= 1'b1;
          scnt_r  <= '0;
        end
        default: ;
      endcase
      if (sbusy_r) begin
        scnt_r <= scnt_r + 5'd1;
        if (scnt_r == 5'd31) begin
          sbusy_r <= 1'b0;
          sdone_r <= 1'b1;
        end
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: close_r <= in_tdata;
      OP_RET_START: ret_neg_r <= diff[32];
      OP_RET_FIN: begin
        e_bad_r <= 1'b0;
        if (ret_neg_r) begin
          e_val_r <= sat_neg ? 32'sh8000_0000 : 32'(-qm[31:0]);
        end else begin
          e_val_r <= sat_pos ? 32'sh7FFF_FFFF : div_q[31:0];
        end
      end
      OP_RET_BAD: begin
        e_bad_r <= 1'b1;
        e_val_r <= '0;
      end
      OP_SQ_OLD, OP_SQ_NEW, OP_MM: prod_r <= mul_p[63:0];
      OP_MEAN_FIN: m_r <= div_q[31:0];
      OP_MSQ_FIN: sqm_r <= div_q;
      OP_VAR: begin
        var_nonpos_r <= v[64] || (v == '0);
        // times 252 as 256 minus 4
        rad_r <= {v[55:0], 8'b0} - {v[61:0], 2'b0};
      end
      OP_SQRT_START: begin
        x_r    <= rad_r;
        srem_r <= '0;
        root_r <= '0;
      end
      OP_EMIT: begin
        out_reason_r <= cmd.reason;
        out_tenths_r <= (cmd.reason == REASON_VALID) ? tenths : '0;
      end
      default: ;
    endcase
    if (sbusy_r) begin
      x_r    <= {x_r[61:0], 2'b00};
      srem_r <= sfits ? 35'(srem_t - strial) : srem_t;
      root_r <= {root_r[30:0], sfits};
    end
  end

  assign status.first       = bars_r == '0;
  assign status.prev_nonpos = prev_r <= 0;
  assign status.full        = {1'b0, bars_r} >= win_p1;
  assign status.bad_any     = bad_r != '0;
  assign status.var_nonpos  = var_nonpos_r;
  assign status.div_done    = div_done;
  assign status.sqrt_done   = sdone_r;
  assign status.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_tenths_r};
  assign out_tuser  = out_reason_r;

endmodule

>>> rtl/vte_ctrl.sv
// controller state machine, sequences one close through the datapath
// depends on vte_pkg
`timescale 1ns / 1ps

module vte_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  vte_pkg::status_t status,
  output vte_pkg::cmd_t    cmd
);

  import vte_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RET_WAIT, S_READ, S_OLD_SQ, S_OLD_SUB, S_NEW_SQ,
    S_NEW_ADD, S_HIST, S_DECIDE, S_MEAN_WAIT, S_MSQ, S_MSQ_WAIT, S_MM,
    S_VAR, S_VCHK, S_SQRT_WAIT, S_TGT, S_TGT_WAIT, S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  reason_t reason_r, reason_nxt;

  always_comb begin
    state_nxt  = state_r;
    reason_nxt = reason_r;
    cmd.op     = OP_NONE;
    cmd.reason = reason_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.first) begin
          state_nxt = S_HIST;
        end else if (status.prev_nonpos) begin
          cmd.op    = OP_RET_BAD;
          state_nxt = S_READ;
        end else begin
          cmd.op    = OP_RET_START;
          state_nxt = S_RET_WAIT;
        end
      end
      S_RET_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_RET_FIN;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (status.full) begin
          cmd.op    = OP_RD_OLD;
          state_nxt = S_OLD_SQ;
        end else begin
          state_nxt = S_NEW_SQ;
        end
      end
      S_OLD_SQ: begin
        cmd.op    = OP_SQ_OLD;
        state_nxt = S_OLD_SUB;
      end
      S_OLD_SUB: begin
        cmd.op    = OP_SUB_OLD;
        state_nxt = S_NEW_SQ;
      end
      S_NEW_SQ: begin
        cmd.op    = OP_SQ_NEW;
        state_nxt = S_NEW_ADD;
      end
      S_NEW_ADD: begin
        cmd.op    = OP_ADD_NEW;
        state_nxt = S_HIST;
      end
      S_HIST: begin
        cmd.op    = OP_HIST;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.full) begin
          reason_nxt = REASON_WARMUP;
          state_nxt  = S_OUT;
        end else if (status.bad_any) begin
          reason_nxt = REASON_BAD;
          state_nxt  = S_OUT;
        end else begin
          cmd.op    = OP_MEAN_START;
          state_nxt = S_MEAN_WAIT;
        end
      end
      S_MEAN_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_MEAN_FIN;
          state_nxt = S_MSQ;
        end
      end
      S_MSQ: begin
        cmd.op    = OP_MSQ_START;
        state_nxt = S_MSQ_WAIT;
      end
      S_MSQ_WAIT: begin
        if (status.div_done) begin
          cmd.op    = OP_MSQ_FIN;
          state_nxt = S_MM;
        end
      end
      S_MM: begin
        cmd.op    = OP_MM;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        cmd.op    = OP_VAR;
        state_nxt = S_VCHK;
      end
      S_VCHK: begin
        if (status.var_nonpos) begin
          reason_nxt = REASON_ZERO_VAR;
          state_nxt  = S_OUT;
        end else begin
          cmd.op    = OP_SQRT_START;
          state_nxt = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (status.sqrt_done) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        cmd.op    = OP_TGT_START;
        state_nxt = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        if (status.div_done) begin
          reason_nxt = REASON_VALID;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      reason_r <= REASON_VALID;
    end else begin
      state_r  <= state_nxt;
      reason_r <= reason_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

endmodule

>>> sim/vte_checker.sv
// result checker for the volatility target exposure block: watches the close,
// result and register ports, predicts each exposure and compares it
// depends on vte_pkg
`timescale 1ns / 1ps

module vte_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [15:0]                   out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [vte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vte_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            errors,
  output int                            pending,
  output int                            checked
);
  import vte_pkg::*;

  typedef struct {
    logic [TENTHS_W-1:0] tenths;
    reason_t             reason;
  } exposure_t;

  exposure_t exposure_q[$];

  // predictor state
  int                 ret_ring [MAX_WINDOW];
  bit                 bad_ring [MAX_WINDOW];
  int                 ring_pos;
  longint             prev_close;
  int                 bars;
  longint             ret_sum;
  longint unsigned    sq_sum;
  int                 bad_cnt;
  longint unsigned    target_vol;
  longint unsigned    cap_q;
  int                 win_len;

  assign pending = exposure_q.size();

  task automatic report_mismatch(input string msg);
    $display("%0t vte_checker: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sq_trunc(input int r);
    longint s;
    s = longint'(r) * longint'(r);
    return longint'(unsigned'(s)) >> 12;
  endfunction

  function automatic int bar_return(input longint cur, input longint prv);
    longint num;
    longint q;
    num = (cur - prv) * 64'sd1073741824;
    q = num / prv;
    if (num % prv != 0 && num < 0) q--;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return int'(q);
  endfunction

  function automatic void clear_history();
    ring_pos   = 0;
    prev_close = 0;
    bars       = 0;
    ret_sum    = 0;
    sq_sum     = 0;
    bad_cnt    = 0;
  endfunction

  function automatic exposure_t predict_exposure(input logic [31:0] raw);
    exposure_t       e;
    longint          cl;
    int              nv;
    bit              nb;
    longint unsigned abs_sum, m, vol, cap_t, tgt_t;
    longint          v;
    cl = longint'(signed'(raw));
    e.tenths = '0;
    if (bars > 0) begin
      if (prev_close > 0) begin
        nv = bar_return(cl, prev_close);
        nb = 0;
      end else begin
        nv = 0;
        nb = 1;
      end
      // window full: drop the oldest return
      if (bars >= win_len + 1) begin
        ret_sum -= ret_ring[ring_pos];
        sq_sum  -= sq_trunc(ret_ring[ring_pos]);
        if (bad_ring[ring_pos]) bad_cnt--;
      end
      ret_ring[ring_pos] = nv;
      bad_ring[ring_pos] = nb;
      ret_sum += nv;
      sq_sum  += sq_trunc(nv);
      if (nb) bad_cnt++;
      ring_pos++;
      if (ring_pos >= win_len) ring_pos = 0;
    end
    prev_close = cl;
    if (bars < win_len + 1) bars++;

    if (bars < win_len + 1) begin
      e.reason = REASON_WARMUP;
    end else if (bad_cnt > 0) begin
      e.reason = REASON_BAD;
    end else begin
      abs_sum = (ret_sum < 0) ? longint'(unsigned'(-ret_sum)) : longint'(unsigned'(ret_sum));
      m = abs_sum / win_len;
      v = longint'(sq_sum / win_len) - longint'((m * m) >> 12);
      if (v <= 0) begin
        e.reason = REASON_ZERO_VAR;
      end else begin
        vol   = int_sqrt(longint'(unsigned'(v)) * 252);
        cap_t = (cap_q * 10) >> 16;
        tgt_t = (vol != 0) ? (target_vol * 2560) / vol : cap_t;
        e.tenths = TENTHS_W'((tgt_t < cap_t) ? tgt_t : cap_t);
        e.reason = REASON_VALID;
      end
    end
    return e;
  endfunction

  always @(posedge clk) begin
    exposure_t got;
    exposure_t want;
    if (!rst_n) begin
      target_vol = TARGET_RESET;
      cap_q      = CAP_RESET;
      win_len    = WIN_RESET;
      clear_history();
      exposure_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_TARGET: target_vol = cfg_wdata;
          CFG_IDX_CAP:    cap_q = cfg_wdata;
          CFG_IDX_WINDOW: begin
            win_len = cfg_wdata[WIN_W-1:0];
            if (win_len < WIN_MIN) win_len = WIN_MIN;
            if (win_len > MAX_WINDOW) win_len = MAX_WINDOW;
            clear_history();
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) exposure_q.push_back(predict_exposure(in_tdata));
      if (out_tvalid && out_tready) begin
        got.tenths = out_tdata[TENTHS_W-1:0];
        got.reason = reason_t'(out_tuser);
        if (exposure_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tenths=%0d reason=%0d",
                                    got.tenths, got.reason));
        end else begin
          want = exposure_q.pop_front();
          checked++;
          if (out_tdata[15:TENTHS_W] != '0)
            report_mismatch($sformatf("result %0d: padding bits %h", checked, out_tdata));
          if (got.tenths != want.tenths)
            report_mismatch($sformatf("result %0d: tenths %0d, expected %0d",
                                      checked, got.tenths, want.tenths));
          if (got.reason != want.reason)
            report_mismatch($sformatf("result %0d: reason %s, expected %s",
                                      checked, got.reason.name(), want.reason.name()));
        end
      end
    end
  end

endmodule

>>> sim/tb_volatility_target_exposure.sv
// testbench top for the volatility target exposure block: drives closes and
// register writes, stalls the result side, and reports the verdict
// depends on vte_pkg, vte_checker and the block itself
`timescale 1ns / 1ps

module tb_volatility_target_exposure;
  import vte_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;    // [31:0] close_price (signed)
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;   // [11:0] exposure_tenths, rest zero
  logic [1:0]           out_tuser;   // [1:0] zero_reason
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int errors;
  int pending;
  int checked;
  int sent;
  int phases;

  // no-idle stretches for both sides
  bit quiet;

  // random walk state for well-formed price series
  longint walk_price;
  int     walk_shift;
  bit     walk_flat;

  volatility_target_exposure u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  vte_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("tb_volatility_target_exposure: done, errors");
    $finish;
  end

  // result side: random stall before each transaction
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // one close transaction; valid stays high across back-to-back closes
  task automatic send_close(input logic [31:0] price);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // lower valid, wait for every result, then idle before the next step
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // unknown index first, then all three registers back to back
  task automatic write_regs(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] cap,
                            input logic [CFG_W-1:0] win);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    idx = '{2'd3, CFG_IDX_TARGET, CFG_IDX_CAP, CFG_IDX_WINDOW};
    val = '{CFG_W'($urandom), tgt, cap, win};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a random walk, with some raw noise and nonpositive closes
  function automatic logic [31:0] next_close();
    int     pick;
    longint step;
    pick = $urandom_range(0, 99);
    if (pick < 6) return $urandom;
    if (pick < 10) return -$urandom_range(0, 1000);
    if (!walk_flat) begin
      step = walk_price >>> walk_shift;
      if (step == 0) step = 1;
      walk_price += longint'($urandom_range(0, 2 * step)) - step;
      if (walk_price < 1) walk_price = 1;
      if (walk_price > 64'sd2147483647) walk_price = 64'sd2147483647;
    end
    return walk_price[31:0];
  endfunction

  initial begin
    logic [31:0]      directed [$];
    logic [CFG_W-1:0] tgt, cap, win;
    int               n_items;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    sent      = 0;
    phases    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window below minimum is taken as two
    write_regs(TARGET_RESET, CAP_RESET, 24'd1);
    // first close, warmup, flat prices (zero variance), a normal move, a drop to zero,
    // a return off a zero close (bad), a negative close and a return off it,
    // upward and downward saturation at the field extremes
    directed = '{32'd1000, 32'd1000, 32'd1000, 32'd1100, 32'd0, 32'd500, 32'd600,
                 32'd700, 32'd700, -32'sd5, 32'd100, 32'd1, 32'd1, 32'd1,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'd1000, 32'd1000, 32'd1003};
    foreach (directed[i]) send_close(directed[i]);
    drain();

    // random phases; the first two run a full-size window, the rest stay small
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       tgt = 24'd0;
        1:       tgt = 24'hff_ffff;
        default: tgt = CFG_W'($urandom_range(0, 200000));
      endcase
      case ($urandom_range(0, 3))
        0:       cap = 24'd0;
        1:       cap = 24'hff_ffff;
        default: cap = CFG_W'($urandom);
      endcase
      if (ph == 0) begin
        win = 24'h00_01ff;   // above the maximum, taken as the maximum
        n_items = 300;
      end else if (ph == 1) begin
        win = 24'hff_fe00 | 24'd256;   // upper bits ignored
        n_items = 290;
      end else begin
        win = CFG_W'($urandom_range(0, 12)) | (CFG_W'($urandom) & 24'hff_fe00);
        n_items = 130;
      end
      write_regs(tgt, cap, win);
      quiet      = (ph % 3 == 2);
      walk_price = $urandom_range(100, 32'h3fff_ffff);
      walk_shift = $urandom_range(3, 14);
      walk_flat  = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 49) == 0) walk_flat = ~walk_flat;
        send_close(next_close());
      end
      drain();
      phases++;
    end
    quiet = 1'b0;

    $display("tb_volatility_target_exposure: %0d closes sent, %0d exposures checked", sent,
             checked);
    $display("tb_volatility_target_exposure: %0d register phases, window 2 to 256", phases + 1);
    if (errors == 0) begin
      $display("tb_volatility_target_exposure: done, clean");
    end else begin
      $display("tb_volatility_target_exposure: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/vte_pkg.sv
rtl/vte_ram.sv
rtl/vte_div.sv
rtl/vte_datapath.sv
rtl/vte_ctrl.sv
rtl/volatility_target_exposure.sv
sim/vte_checker.sv
sim/tb_volatility_target_exposure.sv
